>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property templates for the checker modules of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset disables the check
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");

// next-cycle implication, reset disables the check
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");

`endif

>>> hdl/tbga_pkg.sv
// ----------------------------------------------------------------------------
// tbga_pkg
// Widths, types and saturation helpers of the two-body gravity core.
// ----------------------------------------------------------------------------
package tbga_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int WORD_WIDTH = 32;
   localparam int FIELD_W    = 32;
   localparam int POS_W      = 32;
   localparam int CFG_W      = 32;
   localparam int ADDR_W     = 4;

   localparam int MAG_W      = POS_W + 1;          // |d| below 2^32
   localparam int SQ_W       = 2 * MAG_W;
   localparam int SUM_W      = SQ_W;               // three squares stay below 2^66
   localparam int ROOT_W     = SUM_W / 2;
   localparam int R2_W       = 2 * ROOT_W;
   localparam int R3_W       = 3 * ROOT_W;
   localparam int K_W        = 2 * CFG_W;
   localparam int KD_W       = K_W + MAG_W;
   localparam int QUO_W      = WORD_WIDTH;
   localparam int ACC_NUM_W  = KD_W + FRAC_BITS;
   localparam int POT_NUM_W  = K_W;
   localparam int AMAG_NUM_W = K_W + FRAC_BITS;

   localparam logic [WORD_WIDTH-1:0] SAT_POS_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
   localparam logic [WORD_WIDTH-1:0] SAT_NEG_MAG = {1'b1, {(WORD_WIDTH-1){1'b0}}};
   localparam logic [WORD_WIDTH-1:0] SAT_U_MAX   = {WORD_WIDTH{1'b1}};

   typedef enum logic [1:0] {
      REG_GRAVITY   = 2'd0,
      REG_HOST_MASS = 2'd1,
      REG_SAT_MASS  = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic             ovf;
      logic [QUO_W-1:0] quo;
   } div_result_type;

   typedef struct packed {
      logic [FIELD_W-1:0] host_acc_x;
      logic [FIELD_W-1:0] host_acc_y;
      logic [FIELD_W-1:0] host_acc_z;
      logic [FIELD_W-1:0] sat_acc_x;
      logic [FIELD_W-1:0] sat_acc_y;
      logic [FIELD_W-1:0] sat_acc_z;
      logic [FIELD_W-1:0] host_potential;
      logic [FIELD_W-1:0] sat_potential;
      logic [FIELD_W-1:0] host_acc_magnitude;
      logic [FIELD_W-1:0] sat_acc_magnitude;
      logic               zero_distance;
   } rsp_type;

   function automatic logic [WORD_WIDTH-1:0] sat_signed(div_result_type d, logic neg);
      logic [WORD_WIDTH-1:0] res;
      if (!neg) begin
         res = (d.ovf || d.quo > SAT_POS_MAX) ? SAT_POS_MAX : d.quo;
      end else begin
         res = (d.ovf || d.quo > SAT_NEG_MAG) ? SAT_NEG_MAG : (~d.quo + 1'b1);
      end
      return res;
   endfunction

   function automatic logic [WORD_WIDTH-1:0] sat_unsigned(div_result_type d);
      logic [WORD_WIDTH-1:0] res;
      res = d.ovf ? SAT_U_MAX : d.quo;
      return res;
   endfunction

endpackage

>>> hdl/tbga_sqrt.sv
// ----------------------------------------------------------------------------
// tbga_sqrt
// Pipelined floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module tbga_sqrt #(
   parameter int IN_W = 66
) (
   input  logic                clock,
   input  logic                en,
   input  logic [IN_W-1:0]     din,
   output logic [IN_W/2-1:0]   root
);

   localparam int ROOT_W = IN_W / 2;
   localparam int REM_W  = ROOT_W + 2;

   logic [IN_W-1:0]   rad_ff  [ROOT_W];
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];

   for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
      logic [IN_W-1:0]   rad_prev;
      logic [REM_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [REM_W+1:0]  cur;
      logic [REM_W+1:0]  trial;
      logic              ge;

      if (s == 0) begin : g_first
         assign rad_prev  = din;
         assign rem_prev  = '0;
         assign root_prev = '0;
      end else begin : g_next
         assign rad_prev  = rad_ff[s-1];
         assign rem_prev  = rem_ff[s-1];
         assign root_prev = root_ff[s-1];
      end

      // bring down two radicand bits, try (4*root + 1)
      assign cur   = {rem_prev, rad_prev[IN_W-1 -: 2]};
      assign trial = {2'b00, root_prev, 2'b01};
      assign ge    = (cur >= trial);

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= ge ? REM_W'(cur - trial) : REM_W'(cur);
            root_ff[s] <= {root_prev[ROOT_W-2:0], ge};
            rad_ff[s]  <= rad_prev << 2;
         end
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule

>>> hdl/tbga_div.sv
// ----------------------------------------------------------------------------
// tbga_div
// Pipelined restoring divider with a fixed-width quotient and overflow flag.
// ----------------------------------------------------------------------------
module tbga_div #(
   parameter int NUM_W = 112,
   parameter int DEN_W = 99
) (
   input  logic                         clock,
   input  logic                         en,
   input  logic [NUM_W-1:0]             num,
   input  logic [DEN_W-1:0]             den,
   output tbga_pkg::div_result_type     res
);

   localparam int QUO_W = tbga_pkg::QUO_W;
   localparam int CMP_W = (NUM_W > DEN_W) ? NUM_W : DEN_W;

   logic [DEN_W-1:0] rem_ff [QUO_W+1];
   logic [DEN_W-1:0] den_ff [QUO_W+1];
   logic [QUO_W-1:0] low_ff [QUO_W+1];
   logic [QUO_W-1:0] quo_ff [QUO_W+1];
   logic             ovf_ff [QUO_W+1];

   logic [NUM_W-1:0] num_hi;

   assign num_hi = num >> QUO_W;

   // quotient does not fit when the upper numerator part already reaches den
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= DEN_W'(num_hi);
         den_ff[0] <= den;
         low_ff[0] <= num[QUO_W-1:0];
         quo_ff[0] <= '0;
         ovf_ff[0] <= (CMP_W'(num_hi) >= CMP_W'(den));
      end
   end

   for (genvar s = 1; s <= QUO_W; s++) begin : g_stage
      logic [DEN_W:0] cur;
      logic [DEN_W:0] dext;
      logic           ge;

      assign cur  = {rem_ff[s-1], low_ff[s-1][QUO_W-1]};
      assign dext = {1'b0, den_ff[s-1]};
      assign ge   = (cur >= dext);

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= ge ? DEN_W'(cur - dext) : DEN_W'(cur);
            den_ff[s] <= den_ff[s-1];
            low_ff[s] <= low_ff[s-1] << 1;
            quo_ff[s] <= {quo_ff[s-1][QUO_W-2:0], ge};
            ovf_ff[s] <= ovf_ff[s-1];
         end
      end
   end

   assign res.ovf = ovf_ff[QUO_W];
   assign res.quo = quo_ff[QUO_W];

endmodule

>>> hdl/two_body_gravity_acceleration_core.sv
// ----------------------------------------------------------------------------
// two_body_gravity_acceleration_core
// Newtonian two-body accelerations, potentials and magnitudes in Q16.16.
// ----------------------------------------------------------------------------
// Channel   Handshake                     Payload
// req       req_valid / req_ready         host and satellite positions x/y/z
// rsp       rsp_valid / rsp_ready         accelerations, potentials, magnitudes
// csr       psel penable pwrite pready    paddr, pwdata, prdata (G and masses)
//
// One transaction enters per cycle while the skid is not full. It passes
// 73 register stages: 3 setup, 33 square-root, 3 multiply, 33 divider and the
// write into a two-entry output skid buffer, which drives rsp_valid.
// Synchronous reset clears all valid bits and the skid, and sets G and both
// masses to 1.0. The whole pipeline holds only while both skid entries wait.
// ----------------------------------------------------------------------------
module two_body_gravity_acceleration_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [tbga_pkg::POS_W-1:0]     req_host_x,
   input  logic signed [tbga_pkg::POS_W-1:0]     req_host_y,
   input  logic signed [tbga_pkg::POS_W-1:0]     req_host_z,
   input  logic signed [tbga_pkg::POS_W-1:0]     req_sat_x,
   input  logic signed [tbga_pkg::POS_W-1:0]     req_sat_y,
   input  logic signed [tbga_pkg::POS_W-1:0]     req_sat_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [tbga_pkg::FIELD_W-1:0]   rsp_host_acc_x,
   output logic signed [tbga_pkg::FIELD_W-1:0]   rsp_host_acc_y,
   output logic signed [tbga_pkg::FIELD_W-1:0]   rsp_host_acc_z,
   output logic signed [tbga_pkg::FIELD_W-1:0]   rsp_sat_acc_x,
   output logic signed [tbga_pkg::FIELD_W-1:0]   rsp_sat_acc_y,
   output logic signed [tbga_pkg::FIELD_W-1:0]   rsp_sat_acc_z,
   output logic signed [tbga_pkg::FIELD_W-1:0]   rsp_host_potential,
   output logic signed [tbga_pkg::FIELD_W-1:0]   rsp_sat_potential,
   output logic        [tbga_pkg::FIELD_W-1:0]   rsp_host_acc_magnitude,
   output logic        [tbga_pkg::FIELD_W-1:0]   rsp_sat_acc_magnitude,
   output logic                                  rsp_zero_distance,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [tbga_pkg::ADDR_W-1:0]           paddr,
   input  logic [tbga_pkg::CFG_W-1:0]            pwdata,
   output logic [tbga_pkg::CFG_W-1:0]            prdata,
   output logic                                  pready
);

   localparam int POS_W     = tbga_pkg::POS_W;
   localparam int CFG_W     = tbga_pkg::CFG_W;
   localparam int MAG_W     = tbga_pkg::MAG_W;
   localparam int SQ_W      = tbga_pkg::SQ_W;
   localparam int SUM_W     = tbga_pkg::SUM_W;
   localparam int ROOT_W    = tbga_pkg::ROOT_W;
   localparam int R2_W      = tbga_pkg::R2_W;
   localparam int R3_W      = tbga_pkg::R3_W;
   localparam int K_W       = tbga_pkg::K_W;
   localparam int KD_W      = tbga_pkg::KD_W;
   localparam int FRAC_BITS = tbga_pkg::FRAC_BITS;
   localparam int DIV_LAT   = tbga_pkg::QUO_W + 1;
   localparam int KP_W      = MAG_W + CFG_W;
   localparam logic [CFG_W-1:0] ONE_Q = CFG_W'(1) << FRAC_BITS;
   localparam logic [1:0]       SKID_FULL = 2'd2;

   // ---------------- configuration ----------------
   logic [CFG_W-1:0] gravity_ff, host_mass_ff, sat_mass_ff;
   logic [K_W-1:0]   k_ff [2];   // 0: G*satellite_mass (host), 1: G*host_mass
   logic             csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff   <= ONE_Q;
         host_mass_ff <= ONE_Q;
         sat_mass_ff  <= ONE_Q;
      end else if (csr_wr) begin
         case (tbga_pkg::reg_index_type'(paddr[3:2]))
            tbga_pkg::REG_GRAVITY:   gravity_ff   <= pwdata;
            tbga_pkg::REG_HOST_MASS: host_mass_ff <= pwdata;
            tbga_pkg::REG_SAT_MASS:  sat_mass_ff  <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (tbga_pkg::reg_index_type'(paddr[3:2]))
         tbga_pkg::REG_GRAVITY:   prdata = gravity_ff;
         tbga_pkg::REG_HOST_MASS: prdata = host_mass_ff;
         tbga_pkg::REG_SAT_MASS:  prdata = sat_mass_ff;
         default:                 prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      k_ff[0] <= K_W'(gravity_ff) * K_W'(sat_mass_ff);
      k_ff[1] <= K_W'(gravity_ff) * K_W'(host_mass_ff);
   end

   // ---------------- pipeline control ----------------
   logic       adv;
   logic [1:0] count_ff;

   assign adv       = (count_ff != SKID_FULL);
   assign req_ready = adv;

   logic                v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic [ROOT_W-1:0]   v_dl_ff;
   logic [DIV_LAT-1:0]  v_q_ff;

   // ---------------- stage 1: separation ----------------
   logic [POS_W-1:0] hpos [3];
   logic [POS_W-1:0] spos [3];
   logic [MAG_W-1:0] diff [3];
   logic [MAG_W-1:0] mag1_in [3];

   assign hpos[0] = req_host_x;
   assign hpos[1] = req_host_y;
   assign hpos[2] = req_host_z;
   assign spos[0] = req_sat_x;
   assign spos[1] = req_sat_y;
   assign spos[2] = req_sat_z;

   for (genvar i = 0; i < 3; i++) begin : g_diff
      assign diff[i]    = {hpos[i][POS_W-1], hpos[i]} - {spos[i][POS_W-1], spos[i]};
      assign mag1_in[i] = diff[i][MAG_W-1] ? (~diff[i] + 1'b1) : diff[i];
   end

   logic [MAG_W-1:0] mag1_ff [3], mag2_ff [3], mag3_ff [3];
   logic [2:0]       neg1_ff, neg2_ff, neg3_ff, neg4_ff, neg5_ff, neg6_ff;
   logic [SQ_W-1:0]  sq2_ff [3];
   logic [SUM_W-1:0] sum3_ff;

   // sideband across the square root
   logic [MAG_W-1:0] mag_dl_ff [ROOT_W][3];
   logic [2:0]       neg_dl_ff [ROOT_W];

   logic [ROOT_W-1:0] root;

   logic [ROOT_W-1:0] r4_ff, r5_ff, r6_ff;
   logic [R2_W-1:0]   r2_4_ff, r2_5_ff, r2_6_ff;
   logic [KP_W-1:0]   kdl4_ff [2][3];
   logic [KP_W-1:0]   kdh4_ff [2][3];
   logic              zero4_ff, zero5_ff, zero6_ff;
   logic [KD_W-1:0]   kd5_ff [2][3];
   logic [KD_W-1:0]   kd6_ff [2][3];
   logic [R2_W-1:0]   r3h5_ff, r3l5_ff;
   logic [R3_W-1:0]   r3_6_ff;

   logic [2:0]        neg_q_ff  [DIV_LAT];
   logic              zero_q_ff [DIV_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         v_dl_ff <= '0;
         v4_ff   <= 1'b0;
         v5_ff   <= 1'b0;
         v6_ff   <= 1'b0;
         v_q_ff  <= '0;
      end else if (adv) begin
         v1_ff   <= req_valid;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
         v_dl_ff <= {v_dl_ff[ROOT_W-2:0], v3_ff};
         v4_ff   <= v_dl_ff[ROOT_W-1];
         v5_ff   <= v4_ff;
         v6_ff   <= v5_ff;
         v_q_ff  <= {v_q_ff[DIV_LAT-2:0], v6_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            mag1_ff[i] <= mag1_in[i];
            neg1_ff[i] <= diff[i][MAG_W-1];
            sq2_ff[i]  <= SQ_W'(mag1_ff[i]) * SQ_W'(mag1_ff[i]);
            mag2_ff[i] <= mag1_ff[i];
            mag3_ff[i] <= mag2_ff[i];
         end
         neg2_ff <= neg1_ff;
         neg3_ff <= neg2_ff;
         sum3_ff <= sq2_ff[0] + sq2_ff[1] + sq2_ff[2];

         for (int j = 0; j < ROOT_W; j++) begin
            for (int i = 0; i < 3; i++) begin
               mag_dl_ff[j][i] <= (j == 0) ? mag3_ff[i] : mag_dl_ff[(j == 0) ? 0 : j-1][i];
            end
            neg_dl_ff[j] <= (j == 0) ? neg3_ff : neg_dl_ff[(j == 0) ? 0 : j-1];
         end

         // stage 4: r^2 and K*|d| partial products
         r4_ff    <= root;
         r2_4_ff  <= R2_W'(root) * R2_W'(root);
         zero4_ff <= (root == '0);
         neg4_ff  <= neg_dl_ff[ROOT_W-1];
         for (int b = 0; b < 2; b++) begin
            for (int i = 0; i < 3; i++) begin
               kdl4_ff[b][i] <= KP_W'(mag_dl_ff[ROOT_W-1][i]) * KP_W'(k_ff[b][CFG_W-1:0]);
               kdh4_ff[b][i] <= KP_W'(mag_dl_ff[ROOT_W-1][i]) * KP_W'(k_ff[b][K_W-1:CFG_W]);
            end
         end

         // stage 5: combine K*|d|, r^3 partial products
         for (int b = 0; b < 2; b++) begin
            for (int i = 0; i < 3; i++) begin
               kd5_ff[b][i] <= (KD_W'(kdh4_ff[b][i]) << CFG_W) + KD_W'(kdl4_ff[b][i]);
            end
         end
         r3h5_ff  <= R2_W'(r2_4_ff[R2_W-1:ROOT_W]) * R2_W'(r4_ff);
         r3l5_ff  <= R2_W'(r2_4_ff[ROOT_W-1:0]) * R2_W'(r4_ff);
         r5_ff    <= r4_ff;
         r2_5_ff  <= r2_4_ff;
         zero5_ff <= zero4_ff;
         neg5_ff  <= neg4_ff;

         // stage 6: r^3
         r3_6_ff  <= (R3_W'(r3h5_ff) << ROOT_W) + R3_W'(r3l5_ff);
         kd6_ff   <= kd5_ff;
         r6_ff    <= r5_ff;
         r2_6_ff  <= r2_5_ff;
         zero6_ff <= zero5_ff;
         neg6_ff  <= neg5_ff;

         for (int j = 0; j < DIV_LAT; j++) begin
            neg_q_ff[j]  <= (j == 0) ? neg6_ff  : neg_q_ff[(j == 0) ? 0 : j-1];
            zero_q_ff[j] <= (j == 0) ? zero6_ff : zero_q_ff[(j == 0) ? 0 : j-1];
         end
      end
   end

   tbga_sqrt #(.IN_W(SUM_W)) u_sqrt (
      .clock (clock),
      .en    (adv),
      .din   (sum3_ff),
      .root  (root)
   );

   // ---------------- dividers ----------------
   tbga_pkg::div_result_type acc_res  [2][3];
   tbga_pkg::div_result_type pot_res  [2];
   tbga_pkg::div_result_type amag_res [2];

   for (genvar b = 0; b < 2; b++) begin : g_body
      for (genvar i = 0; i < 3; i++) begin : g_axis
         tbga_div #(.NUM_W(tbga_pkg::ACC_NUM_W), .DEN_W(R3_W)) u_acc_div (
            .clock (clock),
            .en    (adv),
            .num   ({kd6_ff[b][i], {FRAC_BITS{1'b0}}}),
            .den   (r3_6_ff),
            .res   (acc_res[b][i])
         );
      end

      tbga_div #(.NUM_W(tbga_pkg::POT_NUM_W), .DEN_W(ROOT_W)) u_pot_div (
         .clock (clock),
         .en    (adv),
         .num   (k_ff[b]),
         .den   (r6_ff),
         .res   (pot_res[b])
      );

      tbga_div #(.NUM_W(tbga_pkg::AMAG_NUM_W), .DEN_W(R2_W)) u_amag_div (
         .clock (clock),
         .en    (adv),
         .num   ({k_ff[b], {FRAC_BITS{1'b0}}}),
         .den   (r2_6_ff),
         .res   (amag_res[b])
      );
   end

   // ---------------- result assembly ----------------
   tbga_pkg::rsp_type rsp_in;
   logic [2:0]        neg_q;

   assign neg_q = neg_q_ff[DIV_LAT-1];

   // host pulls towards the satellite: sign is opposite to d
   always_comb begin
      rsp_in = '0;
      if (zero_q_ff[DIV_LAT-1]) begin
         rsp_in.zero_distance = 1'b1;
      end else begin
         rsp_in.host_acc_x         = tbga_pkg::sat_signed(acc_res[0][0], !neg_q[0]);
         rsp_in.host_acc_y         = tbga_pkg::sat_signed(acc_res[0][1], !neg_q[1]);
         rsp_in.host_acc_z         = tbga_pkg::sat_signed(acc_res[0][2], !neg_q[2]);
         rsp_in.sat_acc_x          = tbga_pkg::sat_signed(acc_res[1][0], neg_q[0]);
         rsp_in.sat_acc_y          = tbga_pkg::sat_signed(acc_res[1][1], neg_q[1]);
         rsp_in.sat_acc_z          = tbga_pkg::sat_signed(acc_res[1][2], neg_q[2]);
         rsp_in.host_potential     = tbga_pkg::sat_signed(pot_res[0], 1'b1);
         rsp_in.sat_potential      = tbga_pkg::sat_signed(pot_res[1], 1'b1);
         rsp_in.host_acc_magnitude = tbga_pkg::sat_unsigned(amag_res[0]);
         rsp_in.sat_acc_magnitude  = tbga_pkg::sat_unsigned(amag_res[1]);
         rsp_in.zero_distance      = 1'b0;
      end
   end

   // ---------------- output skid ----------------
   tbga_pkg::rsp_type fifo_ff [2];
   tbga_pkg::rsp_type rsp_q;
   logic              wr_ptr_ff, rd_ptr_ff;
   logic              push, pop;

   assign push      = adv && v_q_ff[DIV_LAT-1];
   assign rsp_valid = (count_ff != 2'd0);
   assign pop       = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= rsp_in;
      end
   end

   assign rsp_q                  = fifo_ff[rd_ptr_ff];
   assign rsp_host_acc_x         = rsp_q.host_acc_x;
   assign rsp_host_acc_y         = rsp_q.host_acc_y;
   assign rsp_host_acc_z         = rsp_q.host_acc_z;
   assign rsp_sat_acc_x          = rsp_q.sat_acc_x;
   assign rsp_sat_acc_y          = rsp_q.sat_acc_y;
   assign rsp_sat_acc_z          = rsp_q.sat_acc_z;
   assign rsp_host_potential     = rsp_q.host_potential;
   assign rsp_sat_potential      = rsp_q.sat_potential;
   assign rsp_host_acc_magnitude = rsp_q.host_acc_magnitude;
   assign rsp_sat_acc_magnitude  = rsp_q.sat_acc_magnitude;
   assign rsp_zero_distance      = rsp_q.zero_distance;

endmodule

>>> hdl/tbga_checker.sv
// ----------------------------------------------------------------------------
// tbga_checker
// Port-level assertions for the two-body gravity core, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tbga_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [tbga_pkg::FIELD_W-1:0]  rsp_host_acc_x,
   input logic signed [tbga_pkg::FIELD_W-1:0]  rsp_host_acc_y,
   input logic signed [tbga_pkg::FIELD_W-1:0]  rsp_host_acc_z,
   input logic signed [tbga_pkg::FIELD_W-1:0]  rsp_sat_acc_x,
   input logic signed [tbga_pkg::FIELD_W-1:0]  rsp_sat_acc_y,
   input logic signed [tbga_pkg::FIELD_W-1:0]  rsp_sat_acc_z,
   input logic signed [tbga_pkg::FIELD_W-1:0]  rsp_host_potential,
   input logic signed [tbga_pkg::FIELD_W-1:0]  rsp_sat_potential,
   input logic        [tbga_pkg::FIELD_W-1:0]  rsp_host_acc_magnitude,
   input logic        [tbga_pkg::FIELD_W-1:0]  rsp_sat_acc_magnitude,
   input logic                                 rsp_zero_distance
);

   logic [10*tbga_pkg::FIELD_W:0] rsp_payload;
   logic                          rsp_all_zero;
   logic                          rsp_pots_ok;
   logic                          rsp_stalled;

   assign rsp_payload = {rsp_host_acc_x, rsp_host_acc_y, rsp_host_acc_z,
                         rsp_sat_acc_x, rsp_sat_acc_y, rsp_sat_acc_z,
                         rsp_host_potential, rsp_sat_potential,
                         rsp_host_acc_magnitude, rsp_sat_acc_magnitude,
                         rsp_zero_distance};

   assign rsp_all_zero = (rsp_payload[10*tbga_pkg::FIELD_W:1] == '0);

   assign rsp_pots_ok = (rsp_host_potential[tbga_pkg::FIELD_W-1] || rsp_host_potential == '0)
                     && (rsp_sat_potential[tbga_pkg::FIELD_W-1] || rsp_sat_potential == '0);

   assign rsp_stalled = rsp_valid && !rsp_ready;

   // a stalled transaction stays offered
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stalled, rsp_valid)

   // and keeps its payload
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_stalled, $stable(rsp_payload))

   // coincident bodies give an all-zero result
   `ASSERT_IMPLY(a_zero_result, clock, reset, rsp_valid && rsp_zero_distance, rsp_all_zero)

   // potentials never positive
   `ASSERT_IMPLY(a_pot_sign, clock, reset, rsp_valid, rsp_pots_ok)

   // nothing is offered straight after reset
   `ASSERT_IMPLY(a_reset_empty, clock, reset, $fell(reset), !rsp_valid)

endmodule

bind two_body_gravity_acceleration_core tbga_checker u_tbga_checker (.*);

>>> dv/tb_two_body_gravity_acceleration_core.sv
// ----------------------------------------------------------------------------
// tb_two_body_gravity_acceleration_core
// Self-checking bench for the two-body gravity core. A directed table, then
// random position pairs under several G/mass settings. Every accepted
// transaction without a table value is predicted with exact wide arithmetic and each response is
// compared field by field, in order. Both channels idle and stall in bursts.
// ----------------------------------------------------------------------------
module tb_two_body_gravity_acceleration_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int POS_W        = tbga_pkg::POS_W;
   localparam int FIELD_W      = tbga_pkg::FIELD_W;
   localparam int ADDR_W       = tbga_pkg::ADDR_W;
   localparam int CFG_W        = tbga_pkg::CFG_W;
   localparam int WORD_WIDTH   = tbga_pkg::WORD_WIDTH;
   localparam int FRAC_BITS    = tbga_pkg::FRAC_BITS;
   localparam int DRAIN_CYCLES = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [POS_W-1:0] req_host_x = '0, req_host_y = '0, req_host_z = '0;
   logic signed [POS_W-1:0] req_sat_x = '0, req_sat_y = '0, req_sat_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [FIELD_W-1:0] rsp_host_acc_x, rsp_host_acc_y, rsp_host_acc_z;
   logic signed [FIELD_W-1:0] rsp_sat_acc_x, rsp_sat_acc_y, rsp_sat_acc_z;
   logic signed [FIELD_W-1:0] rsp_host_potential, rsp_sat_potential;
   logic [FIELD_W-1:0] rsp_host_acc_magnitude, rsp_sat_acc_magnitude;
   logic rsp_zero_distance;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0, pready;
   logic [ADDR_W-1:0] paddr = '0;
   logic [CFG_W-1:0] pwdata = '0, prdata;

   two_body_gravity_acceleration_core u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor copy of the configuration
   logic [CFG_W-1:0] grav_g = 32'd65536, host_m = 32'd65536, sat_m = 32'd65536;

   tbga_pkg::rsp_type expected_accels[$];
   int      mismatches = 0;
   bit      calm = 1'b0;       // no idling in the last part of the run
   bit      long_hold = 1'b0;

   typedef struct {
      logic [POS_W-1:0]  pos[6];
      bit                known;
      tbga_pkg::rsp_type exp;
   } accel_row_type;
   accel_row_type accel_table[$];

   function automatic logic [WORD_WIDTH-1:0] clamp_signed(logic [159:0] q, bit neg);
      if (!neg) return (q > 160'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      return (q > 160'h8000_0000) ? 32'h8000_0000 : (~q[31:0] + 32'd1);
   endfunction

   function automatic logic [WORD_WIDTH-1:0] clamp_unsigned(logic [159:0] q);
      return (q > 160'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
   endfunction

   function automatic tbga_pkg::rsp_type gravity_predict(logic [POS_W-1:0] pos[6]);
      tbga_pkg::rsp_type res;
      logic [32:0] mag[3];
      bit          neg[3];
      logic signed [33:0] d;
      logic [159:0] sum, r, t, r2, r3, k_sat, k_host, q;
      res = '0;
      sum = '0;
      for (int i = 0; i < 3; i++) begin
         d = $signed({pos[i][31], pos[i]}) - $signed({pos[i+3][31], pos[i+3]});
         neg[i] = d < 0;
         mag[i] = neg[i] ? 33'(-d) : 33'(d);
         sum += 160'(mag[i]) * 160'(mag[i]);
      end
      r = '0;
      for (int b = 34; b >= 0; b--) begin
         t = r | (160'd1 << b);
         if (t * t <= sum) r = t;
      end
      if (r == 0) begin
         res.zero_distance = 1'b1;
         return res;
      end
      k_sat  = 160'(grav_g) * 160'(sat_m);
      k_host = 160'(grav_g) * 160'(host_m);
      r2 = r * r;
      r3 = r2 * r;
      q = ((k_sat * mag[0]) << FRAC_BITS) / r3;  res.host_acc_x = clamp_signed(q, !neg[0]);
      q = ((k_sat * mag[1]) << FRAC_BITS) / r3;  res.host_acc_y = clamp_signed(q, !neg[1]);
      q = ((k_sat * mag[2]) << FRAC_BITS) / r3;  res.host_acc_z = clamp_signed(q, !neg[2]);
      q = ((k_host * mag[0]) << FRAC_BITS) / r3; res.sat_acc_x = clamp_signed(q, neg[0]);
      q = ((k_host * mag[1]) << FRAC_BITS) / r3; res.sat_acc_y = clamp_signed(q, neg[1]);
      q = ((k_host * mag[2]) << FRAC_BITS) / r3; res.sat_acc_z = clamp_signed(q, neg[2]);
      res.host_potential = clamp_signed(k_sat / r, 1'b1);
      res.sat_potential  = clamp_signed(k_host / r, 1'b1);
      res.host_acc_magnitude = clamp_unsigned((k_sat << FRAC_BITS) / r2);
      res.sat_acc_magnitude  = clamp_unsigned((k_host << FRAC_BITS) / r2);
      return res;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] exp);
      $display("%0t mismatch on %s: got %h, expected %h", $realtime, field, got, exp);
      mismatches++;
   endtask

   // response checker
   always @(posedge clock) begin
      tbga_pkg::rsp_type got, exp;
      string   names[10];
      names = '{"host_acc_x", "host_acc_y", "host_acc_z", "sat_acc_x", "sat_acc_y",
                "sat_acc_z", "host_potential", "sat_potential", "host_acc_magnitude",
                "sat_acc_magnitude"};
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_host_acc_x, rsp_host_acc_y, rsp_host_acc_z, rsp_sat_acc_x,
                 rsp_sat_acc_y, rsp_sat_acc_z, rsp_host_potential, rsp_sat_potential,
                 rsp_host_acc_magnitude, rsp_sat_acc_magnitude, rsp_zero_distance};
         if (expected_accels.size() == 0) begin
            $display("%0t response with no transaction outstanding", $realtime);
            mismatches++;
         end else begin
            exp = expected_accels.pop_front();
            for (int i = 0; i < 10; i++)
               if (got[320-32*i -: 32] !== exp[320-32*i -: 32])
                  report_mismatch(names[i], got[320-32*i -: 32], exp[320-32*i -: 32]);
            if (got.zero_distance !== exp.zero_distance)
               report_mismatch("zero_distance", got.zero_distance, exp.zero_distance);
         end
      end
   end

   // receiver: bursts of stall, one long hold-off on request
   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            n = $urandom_range(1, 16);
            repeat (n) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            n = $urandom_range(1, 24);
            repeat (n) @(posedge clock);
         end
      end
   end

   task automatic send_positions(logic [POS_W-1:0] pos[6], bit known,
                                 tbga_pkg::rsp_type exp);
      int gap;
      gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_host_x <= pos[0];
      req_host_y <= pos[1];
      req_host_z <= pos[2];
      req_sat_x  <= pos[3];
      req_sat_y  <= pos[4];
      req_sat_z  <= pos[5];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_accels.push_back(known ? exp : gravity_predict(pos));
   endtask

   task automatic csr_write(tbga_pkg::reg_index_type idx, logic [CFG_W-1:0] value);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= ADDR_W'(4 * idx);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         tbga_pkg::REG_GRAVITY:   grav_g = value;
         tbga_pkg::REG_HOST_MASS: host_m = value;
         tbga_pkg::REG_SAT_MASS:  sat_m  = value;
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_accels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic add_row(logic [31:0] hx, logic [31:0] hy, logic [31:0] hz,
                          logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                          bit known = 1'b0, tbga_pkg::rsp_type exp = '0);
      accel_row_type row;
      row.pos = '{hx, hy, hz, sx, sy, sz};
      row.known = known;
      row.exp = exp;
      accel_table.push_back(row);
   endtask

   function automatic logic [CFG_W-1:0] random_cfg();
      case ($urandom_range(0, 4))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(0, 32'h0004_0000);
         default: return $urandom;
      endcase
   endfunction

   task automatic random_positions(int count);
      logic [POS_W-1:0] pos[6];
      for (int n = 0; n < count; n++) begin
         for (int i = 0; i < 6; i++) pos[i] = $urandom;
         case ($urandom_range(0, 9))
            0, 1, 2: ; // anywhere in the full range
            3: for (int i = 0; i < 3; i++) pos[i+3] = pos[i]; // coincident
            4: for (int i = 0; i < 3; i++)
                  pos[i+3] = pos[i] + $signed($urandom_range(0, 6)) - 3;
            default: for (int i = 0; i < 3; i++)
                  pos[i+3] = pos[i] + ($urandom >> $urandom_range(4, 28)) *
                             ($urandom_range(0, 1) ? 1 : -1);
         endcase
         send_positions(pos, 1'b0, '0);
      end
   endtask

   initial begin
      logic [31:0] max_p, min_p;
      max_p = 32'h7FFF_FFFF;
      min_p = 32'h8000_0000;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, reset configuration (G and both masses 1.0)
      add_row(32'h0001_0000, 0, 0, 0, 0, 0, 1'b1,
              '{host_acc_x: 32'hFFFF_0000, sat_acc_x: 32'h0001_0000,
                host_potential: 32'hFFFF_0000, sat_potential: 32'hFFFF_0000,
                host_acc_magnitude: 32'h0001_0000, sat_acc_magnitude: 32'h0001_0000,
                default: '0});
      add_row(0, 0, 0, 0, 0, 0, 1'b1, '{zero_distance: 1'b1, default: '0});
      add_row(max_p, max_p, max_p, max_p, max_p, max_p, 1'b1,
              '{zero_distance: 1'b1, default: '0});
      add_row(min_p, min_p, min_p, min_p, min_p, min_p, 1'b1,
              '{zero_distance: 1'b1, default: '0});
      add_row(max_p, 0, 0, min_p, 0, 0);
      add_row(min_p, min_p, min_p, max_p, max_p, max_p);
      add_row(max_p, min_p, max_p, min_p, max_p, min_p);
      add_row(0, 1, 0, 0, 0, 0);                     // one LSB apart, saturates
      add_row(1, 1, 1, 0, 0, 0);
      add_row(0, 0, 32'hFFFE_0000, 0, 0, 32'h0002_0000);
      add_row(32'h0003_0000, 32'hFFFC_0000, 0, 0, 0, 0);
      add_row(32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 0, 0, 0);
      add_row(32'hDEAD_BEEF, 32'h1234_5678, 32'h8765_4321,
              32'h2152_4110, 32'hEDCB_A987, 32'h789A_BCDE);
      foreach (accel_table[i])
         send_positions(accel_table[i].pos, accel_table[i].known, accel_table[i].exp);
      wait_idle();

      // extremes, then zero G, then minimal G and host mass, then random settings; the receiver holds off once
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               csr_write(tbga_pkg::REG_GRAVITY, 32'hFFFF_FFFF);
               csr_write(tbga_pkg::REG_HOST_MASS, 32'hFFFF_FFFF);
               csr_write(tbga_pkg::REG_SAT_MASS, 32'h0);
               long_hold = 1'b1;
            end
            1: begin
               csr_write(tbga_pkg::REG_GRAVITY, 32'h0);
               csr_write(tbga_pkg::REG_SAT_MASS, 32'hFFFF_FFFF);
            end
            2: begin
               csr_write(tbga_pkg::REG_GRAVITY, 32'h0000_0001);
               csr_write(tbga_pkg::REG_HOST_MASS, 32'h0000_0001);
               csr_write(tbga_pkg::REG_SAT_MASS, 32'h0001_0000);
            end
            default: begin
               csr_write(tbga_pkg::REG_GRAVITY, random_cfg());
               csr_write(tbga_pkg::REG_HOST_MASS, random_cfg());
               csr_write(tbga_pkg::REG_SAT_MASS, random_cfg());
            end
         endcase
         if (phase == 4) calm = 1'b1;
         random_positions(108);
         wait_idle();
      end

      if (mismatches == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   initial begin
      #5ms;
      $display("simulation failed");
      $finish;
   end

endmodule

>>> sim.f
+incdir+hdl
hdl/tbga_pkg.sv
hdl/tbga_sqrt.sv
hdl/tbga_div.sv
hdl/two_body_gravity_acceleration_core.sv
hdl/tbga_checker.sv
dv/tb_two_body_gravity_acceleration_core.sv
